// File: rtl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// types and constants shared by the delta list timer queue
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int TIMER_SLOTS = 32;
  localparam int SLOT_W      = 5;
  localparam int LINK_W      = 6;
  localparam int DELAY_W     = 26;
  localparam int TOTAL_W     = DELAY_W + SLOT_W + 1;
  localparam int TICK_MS     = 100;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // x / 100 as (x * DIV_MUL) >> DIV_SHIFT, exact for every 32-bit x
  localparam logic [31:0] DIV_MUL   = 32'h51EB_851F;
  localparam int          DIV_SHIFT = 37;

  localparam logic [LINK_W-1:0]  NIL_LINK  = '1;
  localparam logic [LINK_W-1:0]  SLOTS_L   = LINK_W'(TIMER_SLOTS);
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  typedef enum logic [1:0] {
    OP_CREATE     = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_TICK       = 2'd2,
    OP_REMOVE_ALL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_CREATED = 3'd0,
    EV_EMPTY   = 3'd1,
    EV_REMOVED = 3'd2,
    EV_IGNORED = 3'd3,
    EV_EXPIRED = 3'd4,
    EV_DONE    = 3'd5
  } ev_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] interval_ms;
    logic        periodic;
    logic [4:0]  slot;
    logic [31:0] ticket;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [4:0]  timer_slot;
    logic [31:0] timer_ticket;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [DELAY_W-1:0] ticks;
    logic               periodic;
    logic [SLOT_W-1:0]  slot;
    logic [31:0]        ticket;
  } cmd_t;

  typedef struct packed {
    logic [LINK_W-1:0] running_head;
    logic [LINK_W-1:0] free_head;
  } status_t;

endpackage

// File: rtl/dltq_front.sv
// ----------------------------------------------------------------------------
// dltq_front
// decodes incoming transactions and converts the interval to ticks
// ----------------------------------------------------------------------------
module dltq_front (
  input  logic              in_valid,
  input  dltq_pkg::in_item_t in_data,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output dltq_pkg::cmd_t    q_cmd
);
  import dltq_pkg::*;

  logic [63:0]        prod;
  logic [63-DIV_SHIFT:0] quot;
  logic [DELAY_W-1:0] ticks;

  assign prod = in_data.interval_ms * DIV_MUL;
  assign quot = prod[63:DIV_SHIFT];

  always_comb begin
    if (in_data.interval_ms < 32'(TICK_MS)) begin
      ticks = DELAY_W'(1);
    end else if (quot > (64-DIV_SHIFT)'(DELAY_MAX)) begin
      ticks = DELAY_MAX;
    end else begin
      ticks = quot[DELAY_W-1:0];
    end
  end

  assign in_stall        = q_full;
  assign q_push          = in_valid && !q_full;
  assign q_cmd.op        = op_t'(in_data.operation);
  assign q_cmd.ticks     = ticks;
  assign q_cmd.periodic  = in_data.periodic;
  assign q_cmd.slot      = in_data.slot;
  assign q_cmd.ticket    = in_data.ticket;

endmodule

// File: rtl/dltq_fifo.sv
// ----------------------------------------------------------------------------
// dltq_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module dltq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dltq_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output dltq_pkg::cmd_t pop_cmd,
  output logic           not_empty
);
  import dltq_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/dltq_back.sv
// ----------------------------------------------------------------------------
// dltq_back
// sequencer that keeps the free and running lists and issues results
// ----------------------------------------------------------------------------
module dltq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  dltq_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  output dltq_pkg::out_item_t out_data,
  input  logic                out_stall,
  output dltq_pkg::status_t   status
);
  import dltq_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_CREATE    = 12'b0000_0000_0010,
    S_INS_START = 12'b0000_0000_0100,
    S_INS_WALK  = 12'b0000_0000_1000,
    S_CR_EMIT   = 12'b0000_0001_0000,
    S_RM_CHECK  = 12'b0000_0010_0000,
    S_RM_EMIT   = 12'b0000_0100_0000,
    S_TK_DEC    = 12'b0000_1000_0000,
    S_TK_LOOP   = 12'b0001_0000_0000,
    S_RA_LOOP   = 12'b0010_0000_0000,
    S_REL_A     = 12'b0100_0000_0000,
    S_REL_B     = 12'b1000_0000_0000
  } state_t;

  logic [LINK_W-1:0]  next_link_r  [TIMER_SLOTS];
  logic [LINK_W-1:0]  prev_link_r  [TIMER_SLOTS];
  logic [DELAY_W-1:0] rdelay_r     [TIMER_SLOTS];
  logic [DELAY_W-1:0] reload_r     [TIMER_SLOTS];
  logic               periodic_r   [TIMER_SLOTS];
  logic               running_r    [TIMER_SLOTS];
  logic [31:0]        ticket_r     [TIMER_SLOTS];

  state_t             state_r;
  state_t             ret_r;
  cmd_t               cmd_r;
  logic [LINK_W-1:0]  head_r;
  logic [LINK_W-1:0]  free_r;
  logic [31:0]        ticket_ctr_r;
  logic [31:0]        cr_ticket_r;
  logic [SLOT_W-1:0]  cur_r;
  logic [DELAY_W-1:0] iv_r;
  logic [TOTAL_W-1:0] total_r;
  logic [LINK_W-1:0]  p_r;
  logic [LINK_W-1:0]  t_r;
  logic [LINK_W-1:0]  rel_p_r;
  logic [LINK_W-1:0]  rel_n_r;
  logic [DELAY_W-1:0] rel_d_r;
  logic               rm_ok_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               can_out;
  logic               head_ok;
  logic [SLOT_W-1:0]  head_idx;
  logic [DELAY_W-1:0] head_d;
  logic               free_ok;
  logic [SLOT_W-1:0]  free_idx;
  logic [DELAY_W-1:0] iv;
  logic               t_ok;
  logic [DELAY_W-1:0] t_d;
  logic [TOTAL_W-1:0] walk_sum;
  logic [DELAY_W-1:0] part;
  logic               rel_p_ok;
  logic               rel_n_ok;
  logic [DELAY_W-1:0] rel_n_d;
  logic               rm_ok;
  logic [LINK_W-1:0]  head_next;

  assign can_out   = !out_valid_r || !out_stall;
  assign head_ok   = head_r < SLOTS_L;
  assign head_idx  = head_r[SLOT_W-1:0];
  assign head_d    = rdelay_r[head_idx];
  assign head_next = next_link_r[head_idx];
  assign free_ok   = free_r < SLOTS_L;
  assign free_idx  = free_r[SLOT_W-1:0];
  assign iv        = reload_r[cur_r];
  assign t_ok      = t_r < SLOTS_L;
  assign t_d       = rdelay_r[t_r[SLOT_W-1:0]];
  assign walk_sum  = total_r + TOTAL_W'(t_d);
  assign part      = iv_r - total_r[DELAY_W-1:0];
  assign rel_p_ok  = rel_p_r < SLOTS_L;
  assign rel_n_ok  = rel_n_r < SLOTS_L;
  assign rel_n_d   = rdelay_r[rel_n_r[SLOT_W-1:0]];
  assign rm_ok     = ({1'b0, cmd_r.slot} < SLOTS_L) && running_r[cmd_r.slot] &&
                     (ticket_r[cmd_r.slot] == cmd_r.ticket);

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign status.running_head = head_r;
  assign status.free_head    = free_r;

  always_ff @(posedge clk) begin
    if (state_r == S_CREATE && free_ok) begin
      ticket_r[free_idx] <= ticket_ctr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        next_link_r[i] <= (i + 1 < TIMER_SLOTS) ? LINK_W'(i + 1) : NIL_LINK;
        prev_link_r[i] <= NIL_LINK;
        rdelay_r[i]    <= '0;
        reload_r[i]    <= '0;
        periodic_r[i]  <= 1'b0;
        running_r[i]   <= 1'b0;
      end
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      head_r       <= NIL_LINK;
      free_r       <= '0;
      ticket_ctr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            case (q_cmd.op)
              OP_CREATE:     state_r <= S_CREATE;
              OP_REMOVE:     state_r <= S_RM_CHECK;
              OP_TICK:       state_r <= S_TK_DEC;
              OP_REMOVE_ALL: state_r <= S_RA_LOOP;
              default:       state_r <= S_IDLE;
            endcase
          end
        end
        S_CREATE: begin
          if (!free_ok) begin
            if (can_out) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{event_kind: EV_EMPTY, timer_slot: '0,
                               timer_ticket: '0, last: 1'b1};
              state_r     <= S_IDLE;
            end
          end else begin
            free_r               <= next_link_r[free_idx];
            reload_r[free_idx]   <= cmd_r.ticks;
            periodic_r[free_idx] <= cmd_r.periodic;
            cr_ticket_r          <= ticket_ctr_r;
            ticket_ctr_r         <= ticket_ctr_r + 1'b1;
            cur_r                <= free_idx;
            ret_r                <= S_CR_EMIT;
            state_r              <= S_INS_START;
          end
        end
        S_INS_START: begin
          running_r[cur_r] <= 1'b1;
          rdelay_r[cur_r]  <= iv;
          iv_r             <= iv;
          if (!head_ok) begin
            prev_link_r[cur_r] <= NIL_LINK;
            next_link_r[cur_r] <= NIL_LINK;
            head_r             <= {1'b0, cur_r};
            state_r            <= ret_r;
          end else if (iv <= head_d) begin
            next_link_r[cur_r]    <= head_r;
            prev_link_r[cur_r]    <= NIL_LINK;
            rdelay_r[head_idx]    <= head_d - iv;
            prev_link_r[head_idx] <= {1'b0, cur_r};
            head_r                <= {1'b0, cur_r};
            state_r               <= ret_r;
          end else begin
            p_r     <= head_r;
            t_r     <= head_next;
            total_r <= TOTAL_W'(head_d);
            state_r <= S_INS_WALK;
          end
        end
        S_INS_WALK: begin
          if (!t_ok) begin
            rdelay_r[cur_r]              <= part;
            next_link_r[cur_r]           <= NIL_LINK;
            prev_link_r[cur_r]           <= p_r;
            next_link_r[p_r[SLOT_W-1:0]] <= {1'b0, cur_r};
            state_r                      <= ret_r;
          end else if (TOTAL_W'(iv_r) <= walk_sum) begin
            rdelay_r[cur_r]              <= part;
            next_link_r[cur_r]           <= t_r;
            prev_link_r[cur_r]           <= p_r;
            rdelay_r[t_r[SLOT_W-1:0]]    <= t_d - part;
            prev_link_r[t_r[SLOT_W-1:0]] <= {1'b0, cur_r};
            next_link_r[p_r[SLOT_W-1:0]] <= {1'b0, cur_r};
            state_r                      <= ret_r;
          end else begin
            total_r <= walk_sum;
            p_r     <= t_r;
            t_r     <= next_link_r[t_r[SLOT_W-1:0]];
          end
        end
        S_CR_EMIT: begin
          if (can_out) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{event_kind: EV_CREATED, timer_slot: cur_r,
                             timer_ticket: cr_ticket_r, last: 1'b1};
            state_r     <= S_IDLE;
          end
        end
        S_RM_CHECK: begin
          rm_ok_r <= rm_ok;
          if (rm_ok) begin
            cur_r   <= cmd_r.slot;
            ret_r   <= S_RM_EMIT;
            state_r <= S_REL_A;
          end else begin
            state_r <= S_RM_EMIT;
          end
        end
        S_RM_EMIT: begin
          if (can_out) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{event_kind: (rm_ok_r ? EV_REMOVED : EV_IGNORED),
                             timer_slot: cmd_r.slot, timer_ticket: cmd_r.ticket,
                             last: 1'b1};
            state_r     <= S_IDLE;
          end
        end
        S_TK_DEC: begin
          if (head_ok && head_d != '0) begin
            rdelay_r[head_idx] <= head_d - 1'b1;
          end
          state_r <= S_TK_LOOP;
        end
        S_TK_LOOP: begin
          if (can_out) begin
            out_valid_r <= 1'b1;
            if (head_ok && head_d == '0) begin
              out_data_r <= '{event_kind: EV_EXPIRED, timer_slot: head_idx,
                              timer_ticket: ticket_r[head_idx], last: 1'b0};
              cur_r      <= head_idx;
              ret_r      <= S_TK_LOOP;
              if (periodic_r[head_idx]) begin
                head_r <= head_next;
                if (head_next < SLOTS_L) begin
                  prev_link_r[head_next[SLOT_W-1:0]] <= NIL_LINK;
                end
                state_r <= S_INS_START;
              end else begin
                state_r <= S_REL_A;
              end
            end else begin
              out_data_r <= '{event_kind: EV_DONE, timer_slot: '0,
                              timer_ticket: '0, last: 1'b1};
              state_r    <= S_IDLE;
            end
          end
        end
        S_RA_LOOP: begin
          if (can_out) begin
            out_valid_r <= 1'b1;
            if (head_ok) begin
              out_data_r <= '{event_kind: EV_REMOVED, timer_slot: head_idx,
                              timer_ticket: ticket_r[head_idx], last: 1'b0};
              cur_r      <= head_idx;
              ret_r      <= S_RA_LOOP;
              state_r    <= S_REL_A;
            end else begin
              out_data_r <= '{event_kind: EV_DONE, timer_slot: '0,
                              timer_ticket: '0, last: 1'b1};
              state_r    <= S_IDLE;
            end
          end
        end
        S_REL_A: begin
          rel_p_r <= prev_link_r[cur_r];
          rel_n_r <= next_link_r[cur_r];
          rel_d_r <= rdelay_r[cur_r];
          state_r <= S_REL_B;
        end
        S_REL_B: begin
          if (!rel_p_ok && !rel_n_ok) begin
            if (head_r == {1'b0, cur_r}) begin
              head_r <= NIL_LINK;
            end
          end else if (!rel_p_ok) begin
            head_r                           <= rel_n_r;
            rdelay_r[rel_n_r[SLOT_W-1:0]]    <= rel_n_d + rel_d_r;
            prev_link_r[rel_n_r[SLOT_W-1:0]] <= NIL_LINK;
          end else if (!rel_n_ok) begin
            next_link_r[rel_p_r[SLOT_W-1:0]] <= NIL_LINK;
          end else begin
            next_link_r[rel_p_r[SLOT_W-1:0]] <= rel_n_r;
            prev_link_r[rel_n_r[SLOT_W-1:0]] <= rel_p_r;
            rdelay_r[rel_n_r[SLOT_W-1:0]]    <= rel_n_d + rel_d_r;
          end
          reload_r[cur_r]    <= '0;
          rdelay_r[cur_r]    <= '0;
          running_r[cur_r]   <= 1'b0;
          prev_link_r[cur_r] <= NIL_LINK;
          next_link_r[cur_r] <= free_r;
          free_r             <= {1'b0, cur_r};
          state_r            <= ret_r;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/delta_list_timer_queue.sv
// the queue registers each accepted command before the sequencer takes it
// create: walks past running timers to find its place; pool empty: empty result
// remove: releases the timer, or is ignored; remove-all: releases each timer, then done
// tick: frees each expired one-shot, re-walks each expired periodic timer, then done
// synchronous reset loads all link and delay flops at once; no clearing pass
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// timer pool with free list and delta-ordered running list
// ----------------------------------------------------------------------------
module delta_list_timer_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  dltq_pkg::in_item_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output dltq_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import dltq_pkg::*;

  logic    push;
  cmd_t    push_cmd;
  logic    full;
  logic    pop;
  cmd_t    pop_cmd;
  logic    not_empty;
  status_t status;

  dltq_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  dltq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (not_empty)
  );

  dltq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (not_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .status    (status)
  );

`ifndef ASSERT_OFF
  a_lists_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    !((status.free_head < SLOTS_L) && (status.free_head == status.running_head)))
    else $error("free and running list share a head");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_kind == EV_DONE) |->
      (out_data.last && out_data.timer_slot == '0 && out_data.timer_ticket == '0))
    else $error("done result carries payload");

  a_not_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |->
      (out_data.event_kind == EV_EXPIRED || out_data.event_kind == EV_REMOVED))
    else $error("unexpected intermediate result");
`endif

endmodule
